/* design/aqsa_pkg.sv */
package aqsa_pkg;

  // field and register widths
  localparam int SAMPLE_W     = 16;
  localparam int SQ_W         = 32;
  localparam int SENS_W       = 11;
  localparam int CHAN_W       = 4;
  localparam int CROSS_AVG_W  = 17;
  localparam int ENERGY_AVG_W = 33;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  // width of (9 * old + new + 5) for the energy average
  localparam int AVG_NW       = 36;
  // widths of the scaled averages used by the decision
  localparam int ZL_W         = CROSS_AVG_W + 7;
  localparam int EL_W         = ENERGY_AVG_W + 7;
  localparam int THR_W        = 14;
  localparam int ZT_W         = THR_W + 6;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_SENSITIVITY = 2'd0;
  localparam logic [1:0] REG_ADAPT       = 2'd1;
  localparam logic [1:0] REG_FORCED_HIGH = 2'd2;
  localparam logic [1:0] REG_CHANNELS    = 2'd3;

  // register reset values
  localparam logic [SENS_W-1:0] SENS_RESET  = 11'd512;
  localparam logic [CHAN_W-1:0] CHAN_RESET  = 4'd2;

  // arithmetic constants
  localparam logic [SENS_W-1:0] SENS_MAX    = 11'd1024;
  localparam logic [THR_W-1:0]  THR_BASE    = 14'd11264;
  localparam logic [3:0]        AVG_ROUND   = 4'd5;
  localparam logic [3:0]        AVG_DIV     = 4'd10;
  localparam logic [6:0]        DEC_SCALE   = 7'd100;
  localparam logic [EL_W-1:0]   ENERGY_THR  = 40'h00_4000_0000;

  typedef struct packed {
    logic [SENS_W-1:0] sensitivity;
    logic              adaptation_enabled;
    logic              forced_high;
    logic [CHAN_W-1:0] channel_count;
  } cfg_t;

endpackage

/* design/aqsa_cfg.sv */
module aqsa_cfg
  import aqsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensitivity        <= SENS_RESET;
      cfg.adaptation_enabled <= 1'b1;
      cfg.forced_high        <= 1'b1;
      cfg.channel_count      <= CHAN_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SENSITIVITY: cfg.sensitivity        <= pwdata[SENS_W-1:0];
        REG_ADAPT:       cfg.adaptation_enabled <= pwdata[0];
        REG_FORCED_HIGH: cfg.forced_high        <= pwdata[0];
        REG_CHANNELS:    cfg.channel_count      <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[3:2])
      REG_SENSITIVITY: prdata = PDATA_W'(cfg.sensitivity);
      REG_ADAPT:       prdata = PDATA_W'(cfg.adaptation_enabled);
      REG_FORCED_HIGH: prdata = PDATA_W'(cfg.forced_high);
      REG_CHANNELS:    prdata = PDATA_W'(cfg.channel_count);
      default:         prdata = '0;
    endcase
  end

endmodule

/* design/aqsa_sqr.sv */
module aqsa_sqr
  import aqsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] operand,
  output logic                done,
  output logic [SQ_W-1:0]     product
);

  localparam int CNT_W = $clog2(SAMPLE_W + 1);

  logic [SAMPLE_W-1:0] mcand;
  logic [SAMPLE_W-1:0] hi;
  logic [SAMPLE_W-1:0] lo;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic [SAMPLE_W:0]   sum;

  // one multiplier bit per cycle, the low half doubles as the multiplier
  assign sum     = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SAMPLE_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // shift-add datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= operand;
      hi    <= '0;
      lo    <= operand;
    end else if (busy) begin
      hi <= sum[SAMPLE_W:1];
      lo <= {sum[0], lo[SAMPLE_W-1:1]};
    end
  end

endmodule

/* design/aqsa_div.sv */
module aqsa_div #(
  parameter int NW = 43,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]  num_sr;
  logic [DW-1:0]  den_r;
  logic [DW-1:0]  rem;
  logic [DW:0]    rem_sh;
  logic           ge;
  logic [DW:0]    rem_sub;
  logic [CNT_W-1:0] cnt;
  logic           busy;

  // restoring step, one quotient bit per cycle
  assign rem_sh  = {rem, num_sr[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign quot    = num_sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sr <= num;
      den_r  <= den;
      rem    <= '0;
    end else if (busy) begin
      rem    <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      num_sr <= {num_sr[NW-2:0], ge};
    end
  end

endmodule

/* design/adaptive_quality_signal_analyzer.sv */
// a word that is not analysed is taken without stalling the input; an analysed word stalls the
// input while the 16-step serial squarer runs
// block end: with adaptation on, the result word waits on the bit-serial divider (width NW = 32 +
// taken-count bits, at least 36), shared by the four divisions; an empty block skips the
// divisions, and with adaptation off the result goes straight to the output state
// reset (synchronous): registers to defaults, averages cleared, high quality selected
module adaptive_quality_signal_analyzer
  import aqsa_pkg::*;
#(
  parameter int MAX_BLOCK_FRAMES = 4096,
  parameter int STRIDE           = 4,
  parameter int MAX_CHANNELS     = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                    block_end,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic                    use_high_quality,
  output logic                    start_crossfade,
  output logic [CROSS_AVG_W-1:0]  crossing_average,
  output logic [ENERGY_AVG_W-1:0] energy_average
);

  localparam int TAKE_LIMIT = (MAX_BLOCK_FRAMES + STRIDE - 1) / STRIDE;
  localparam int TW   = $clog2(TAKE_LIMIT + 1);
  localparam int ESW  = SQ_W + TW;
  localparam int NW   = (ESW > AVG_NW) ? ESW : AVG_NW;
  localparam int DW   = (TW > 4) ? TW : 4;
  localparam int PW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNW0 = $clog2(MAX_CHANNELS + 1);
  localparam int CNW  = (CNW0 > CHAN_W) ? CNW0 : CHAN_W;
  localparam int FW   = (STRIDE > 1) ? $clog2(STRIDE) : 1;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_SQR     = 10'b0000000010,
    ST_END     = 10'b0000000100,
    ST_DIV_Z   = 10'b0000001000,
    ST_DIV_E   = 10'b0000010000,
    ST_AVG_Z   = 10'b0000100000,
    ST_AVG_E   = 10'b0001000000,
    ST_DEC_MUL = 10'b0010000000,
    ST_DEC_CMP = 10'b0100000000,
    ST_OUT     = 10'b1000000000
  } state_t;

  cfg_t   cfg;
  state_t state;

  logic signed [SAMPLE_W-1:0] prev;
  logic [PW-1:0]              pos;
  logic [FW-1:0]              phase;
  logic [TW-1:0]              crossing_cnt;
  logic [TW-1:0]              taken_cnt;
  logic [ESW-1:0]             energy_sum;
  logic [CROSS_AVG_W-1:0]     ch_hist;
  logic [ENERGY_AVG_W-1:0]    eh_hist;
  logic                       high_sel;
  logic                       last;
  logic                       choice;

  logic [CROSS_AVG_W-1:0]     zr;
  logic [SQ_W-1:0]            en;
  logic [ZL_W-1:0]            zl;
  logic [EL_W-1:0]            el;
  logic [ZT_W-1:0]            zthr;

  logic                       acc;
  logic                       take;
  logic [CNW-1:0]             chans_raw;
  logic [CNW-1:0]             chans;
  logic [CNW-1:0]             pos_inc;
  logic [FW:0]                ph_inc;
  logic signed [SAMPLE_W:0]   delta;
  logic [SAMPLE_W:0]          delta_abs;
  logic [SENS_W-1:0]          sens_eff;
  logic [THR_W-1:0]           thr;
  logic [AVG_NW-1:0]          avg_z_num;
  logic [AVG_NW-1:0]          avg_e_num;
  logic                       out_free;

  logic                       sqr_start;
  logic                       sqr_done;
  logic [SQ_W-1:0]            sq_prod;
  logic                       div_start;
  logic                       div_done;
  logic [NW-1:0]              div_num;
  logic [DW-1:0]              div_den;
  logic [NW-1:0]              quot;

  aqsa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aqsa_sqr u_sqr (
    .clk     (clk),
    .rst     (rst),
    .start   (sqr_start),
    .operand (delta_abs[SAMPLE_W-1:0]),
    .done    (sqr_done),
    .product (sq_prod)
  );

  aqsa_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // input handshake and sample selection
  assign sample_stall = (state != ST_IDLE);
  assign acc          = sample_valid && !sample_stall;
  assign take         = (pos == '0) && (phase == '0) && (taken_cnt < TW'(TAKE_LIMIT));
  assign sqr_start    = acc && take;

  // channel count limited to 1..MAX_CHANNELS
  assign chans_raw = CNW'(cfg.channel_count);
  always_comb begin
    if (chans_raw == '0) begin
      chans = CNW'(1);
    end else if (chans_raw > CNW'(MAX_CHANNELS)) begin
      chans = CNW'(MAX_CHANNELS);
    end else begin
      chans = chans_raw;
    end
  end
  assign pos_inc = CNW'(pos) + 1'b1;
  assign ph_inc  = (FW + 1)'(phase) + 1'b1;

  // delta to the previous taken sample and its magnitude
  assign delta     = {sample[SAMPLE_W-1], sample} - {prev[SAMPLE_W-1], prev};
  assign delta_abs = delta[SAMPLE_W] ? (~delta + 1'b1) : delta;

  // averaging numerators: nine times old plus new plus rounding
  assign avg_z_num = (AVG_NW'(ch_hist) << 3) + AVG_NW'(ch_hist) + AVG_NW'(zr)
                   + AVG_NW'(AVG_ROUND);
  assign avg_e_num = (AVG_NW'(eh_hist) << 3) + AVG_NW'(eh_hist) + AVG_NW'(en)
                   + AVG_NW'(AVG_ROUND);

  // crossing threshold, 11264 - 10 * sensitivity
  assign sens_eff = (cfg.sensitivity > SENS_MAX) ? SENS_MAX : cfg.sensitivity;
  assign thr      = THR_BASE - ((THR_W'(sens_eff) << 3) + (THR_W'(sens_eff) << 1));

  // divider operand selection, each division starts as the previous one ends
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DW'(AVG_DIV);
    case (state)
      ST_END: begin
        div_start = cfg.adaptation_enabled && (taken_cnt != '0);
        div_num   = NW'({crossing_cnt, 16'b0});
        div_den   = DW'(taken_cnt);
      end
      ST_DIV_Z: begin
        div_start = div_done;
        div_num   = NW'(energy_sum);
        div_den   = DW'(taken_cnt);
      end
      ST_DIV_E: begin
        div_start = div_done;
        div_num   = NW'(avg_z_num);
      end
      ST_AVG_Z: begin
        div_start = div_done;
        div_num   = NW'(avg_e_num);
      end
      default: ;
    endcase
  end

  assign out_free = !result_valid || !result_stall;

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      prev         <= '0;
      pos          <= '0;
      phase        <= '0;
      crossing_cnt <= '0;
      taken_cnt    <= '0;
      energy_sum   <= '0;
      ch_hist      <= '0;
      eh_hist      <= '0;
      high_sel     <= 1'b1;
      last         <= 1'b0;
      choice       <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      // taken word leaves unless a new one replaces it
      if (result_valid && !result_stall && state != ST_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (pos_inc >= chans) begin
              pos   <= '0;
              phase <= (ph_inc == (FW + 1)'(STRIDE)) ? '0 : ph_inc[FW-1:0];
            end else begin
              pos <= pos_inc[PW-1:0];
            end
            last <= block_end;
            if (take) begin
              prev      <= sample;
              taken_cnt <= taken_cnt + 1'b1;
              if (sample[SAMPLE_W-1] != prev[SAMPLE_W-1]) begin
                crossing_cnt <= crossing_cnt + 1'b1;
              end
              state <= ST_SQR;
            end else if (block_end) begin
              state <= ST_END;
            end
          end
        end
        ST_SQR: begin
          if (sqr_done) begin
            energy_sum <= energy_sum + ESW'(sq_prod);
            state      <= last ? ST_END : ST_IDLE;
          end
        end
        ST_END: begin
          if (!cfg.adaptation_enabled) begin
            choice <= cfg.forced_high;
            state  <= ST_OUT;
          end else if (taken_cnt == '0) begin
            state <= ST_DEC_MUL;
          end else begin
            state <= ST_DIV_Z;
          end
        end
        ST_DIV_Z: begin
          if (div_done) begin
            state <= ST_DIV_E;
          end
        end
        ST_DIV_E: begin
          if (div_done) begin
            state <= ST_AVG_Z;
          end
        end
        ST_AVG_Z: begin
          if (div_done) begin
            ch_hist <= quot[CROSS_AVG_W-1:0];
            state   <= ST_AVG_E;
          end
        end
        ST_AVG_E: begin
          if (div_done) begin
            eh_hist <= quot[ENERGY_AVG_W-1:0];
            state   <= ST_DEC_MUL;
          end
        end
        ST_DEC_MUL: begin
          state <= ST_DEC_CMP;
        end
        ST_DEC_CMP: begin
          choice <= (zl > ZL_W'(zthr)) || (el > ENERGY_THR);
          state  <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            high_sel     <= choice;
            prev         <= '0;
            pos          <= '0;
            phase        <= '0;
            crossing_cnt <= '0;
            taken_cnt    <= '0;
            energy_sum   <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // division results and scaled decision operands (averages times 100, threshold times 64, as shifts)
  always_ff @(posedge clk) begin
    if (state == ST_DIV_Z && div_done) begin
      zr <= quot[CROSS_AVG_W-1:0];
    end
    if (state == ST_DIV_E && div_done) begin
      en <= quot[SQ_W-1:0];
    end
    if (state == ST_DEC_MUL) begin
      zl   <= (ZL_W'(ch_hist) << 6) + (ZL_W'(ch_hist) << 5) + (ZL_W'(ch_hist) << 2);
      el   <= (EL_W'(eh_hist) << 6) + (EL_W'(eh_hist) << 5) + (EL_W'(eh_hist) << 2);
      zthr <= {thr, 6'b0};
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      use_high_quality <= choice;
      start_crossfade  <= (choice != high_sel);
      crossing_average <= ch_hist;
      energy_average   <= eh_hist;
    end
  end

  a_taken_bound: assert property (@(posedge clk) disable iff (rst)
    taken_cnt <= TW'(TAKE_LIMIT))
    else $error("taken count beyond block bound");

  a_cross_le_taken: assert property (@(posedge clk) disable iff (rst)
    crossing_cnt <= taken_cnt)
    else $error("more crossings than taken samples");

  a_sqr_owned: assert property (@(posedge clk) disable iff (rst)
    sqr_done |-> state == ST_SQR)
    else $error("squarer finished outside its wait state");

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_Z || state == ST_DIV_E ||
                  state == ST_AVG_Z || state == ST_AVG_E))
    else $error("divider finished outside a division state");

  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && result_valid && result_stall) |=> state == ST_OUT)
    else $error("result dropped while output word still pending");

endmodule
